@@ hdl/grouped_complex_max_magnitude_macros.svh @@
// Assertion shorthands used by the checker file.
`ifndef GROUPED_COMPLEX_MAX_MAGNITUDE_MACROS_SVH
`define GROUPED_COMPLEX_MAX_MAGNITUDE_MACROS_SVH

// ante holds at an edge (reset inactive) -> cons holds at the next edge
`define GCMM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// checked across reset: at the edge after reset is sampled, cons must hold
`define GCMM_ASSERT_AFTER_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) else $error(msg);

`endif

@@ hdl/gcmm_pkg.sv @@
package gcmm_pkg;

    localparam int NUM_BINS        = 1024;
    localparam int COMPONENT_WIDTH = 16;
    localparam int BIN_AW          = $clog2(NUM_BINS);
    localparam int INDEX_W         = 10;
    localparam int OP_W            = 2;
    // sum of two squares of COMPONENT_WIDTH-bit signed values
    localparam int MAG_W           = 2 * COMPONENT_WIDTH;

    localparam logic [OP_W-1:0] OP_ACCUM      = 2'd0;
    localparam logic [OP_W-1:0] OP_READ_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 2'd2;

    typedef enum logic {
        ST_SWEEP,
        ST_RUN
    } t_state;

    // one bin as held in memory; mag caches re*re + im*im
    typedef struct packed {
        logic                              valid;
        logic signed [COMPONENT_WIDTH-1:0] re;
        logic signed [COMPONENT_WIDTH-1:0] im;
        logic [MAG_W-1:0]                  mag;
    } t_bin_entry;

endpackage

@@ hdl/gcmm_bin_ram.sv @@
module gcmm_bin_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/grouped_complex_max_magnitude.sv @@
// Per-bin maximum-magnitude tracker for complex samples. Each of the NUM_BINS bins
// holds one complex value in a single-port-write / single-port-read RAM together
// with its squared magnitude and a valid flag. An accumulate request (opcode 0)
// reads its bin, compares the sample's exact squared magnitude against the held one
// and writes the winner back; a tie keeps the held value. A read request (opcode 1)
// returns the bin and clears it; an empty bin reads as (empty_real_value, 0).
// A clear-all request (opcode 2) sweeps the RAM, one entry per cycle.
// Timing: accumulate and read requests are taken one per cycle unless o_stall is high;
// the RAM read is issued on acceptance and the compare/write-back happens the following
// cycle (a read waits there while the output register holds a stalled result), with a
// one-entry bypass of the last write-back covering a request that hits the same bin.
// A read result passes through the compare stage register and then the output register
// to o_valid. A clear-all request stalls the input until its sweep of the RAM is done.
// After reset the same sweep runs before the first request is taken; register writes are taken at any time.
// The input stalls while a read result waits in the output register and the next
// read is ready to complete behind it.
module grouped_complex_max_magnitude (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // configuration: empty_real_value
    input  logic                                       i_cfg_wr_en,
    input  logic signed [gcmm_pkg::COMPONENT_WIDTH-1:0] i_cfg_wr_data,
    // request channel
    input  logic                                       i_valid,
    output logic                                       o_stall,
    input  logic [gcmm_pkg::OP_W-1:0]                  i_opcode,
    input  logic [gcmm_pkg::INDEX_W-1:0]               i_bin_index,
    input  logic signed [gcmm_pkg::COMPONENT_WIDTH-1:0] i_sample_real,
    input  logic signed [gcmm_pkg::COMPONENT_WIDTH-1:0] i_sample_imag,
    // result channel
    output logic                                       o_valid,
    input  logic                                       i_stall,
    output logic [gcmm_pkg::INDEX_W-1:0]               o_result_index,
    output logic signed [gcmm_pkg::COMPONENT_WIDTH-1:0] o_max_real,
    output logic signed [gcmm_pkg::COMPONENT_WIDTH-1:0] o_max_imag
);

    import gcmm_pkg::*;

    localparam int CW = COMPONENT_WIDTH;

    // sweep / run control
    t_state             r_state;
    t_state             n_state;
    logic [BIN_AW-1:0]  r_sweep_addr;
    logic [BIN_AW-1:0]  n_sweep_addr;
    logic               sweeping;

    // empty bin value and its squared magnitude
    logic signed [CW-1:0]    r_empty_real;
    logic [MAG_W-1:0]        r_empty_mag;
    logic signed [MAG_W-1:0] cfg_sq;

    // compare stage
    logic                    r_s1_valid;
    logic [OP_W-1:0]         r_s1_op;
    logic [INDEX_W-1:0]      r_s1_idx;
    logic signed [CW-1:0]    r_s1_re;
    logic signed [CW-1:0]    r_s1_im;
    logic [MAG_W-2:0]        r_s1_sq_re;
    logic [MAG_W-2:0]        r_s1_sq_im;
    logic signed [MAG_W-1:0] in_sq_re;
    logic signed [MAG_W-1:0] in_sq_im;

    // bypass of the last write-back
    logic               r_fwd_valid;
    logic [BIN_AW-1:0]  r_fwd_addr;
    t_bin_entry         r_fwd_data;

    // output register
    logic                 r_out_valid;
    logic [INDEX_W-1:0]   r_out_idx;
    logic signed [CW-1:0] r_out_re;
    logic signed [CW-1:0] r_out_im;

    // RAM ports
    logic               ram_wr_en;
    logic [BIN_AW-1:0]  ram_wr_addr;
    t_bin_entry         ram_wr_data;
    t_bin_entry         ram_rd_data;

    logic                 in_acc;
    logic                 out_free;
    logic                 s1_go;
    logic                 s1_in_range;
    logic                 s1_wr;
    logic [BIN_AW-1:0]    s1_addr;
    t_bin_entry           cur;
    logic signed [CW-1:0] cur_re;
    logic signed [CW-1:0] cur_im;
    logic [MAG_W-1:0]     cur_mag;
    logic [MAG_W-1:0]     s_mag;
    logic                 take;
    t_bin_entry           wb_entry;

    gcmm_bin_ram #(
        .DEPTH (NUM_BINS),
        .WIDTH ($bits(t_bin_entry))
    ) u_bin_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_bin_index[BIN_AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    // ---------------------------------------------------------------- handshake
    assign out_free = !r_out_valid || !i_stall;
    // a read can only finish when the output register has room
    assign s1_go    = r_s1_valid && !(r_s1_op == OP_READ_CLEAR && !out_free);
    assign o_stall  = sweeping
                   || (r_s1_valid && r_s1_op == OP_CLEAR_ALL)
                   || (r_s1_valid && !s1_go);
    assign in_acc   = i_valid && !o_stall;

    // ---------------------------------------------------------------- compare stage
    assign in_sq_re = MAG_W'(i_sample_real) * MAG_W'(i_sample_real);
    assign in_sq_im = MAG_W'(i_sample_imag) * MAG_W'(i_sample_imag);

    assign s1_addr     = r_s1_idx[BIN_AW-1:0];
    assign s1_in_range = int'(r_s1_idx) < NUM_BINS;

    // RAM read was issued alongside the write of the previous request: bypass it
    assign cur     = (r_fwd_valid && r_fwd_addr == s1_addr) ? r_fwd_data : ram_rd_data;
    assign cur_re  = cur.valid ? cur.re  : r_empty_real;
    assign cur_im  = cur.valid ? cur.im  : '0;
    assign cur_mag = cur.valid ? cur.mag : r_empty_mag;

    assign s_mag = MAG_W'(r_s1_sq_re) + MAG_W'(r_s1_sq_im);
    assign take  = s_mag > cur_mag;   // strict: a tie keeps the held value

    always_comb begin
        wb_entry = '0;
        case (r_s1_op)
            OP_ACCUM: begin
                wb_entry.valid = 1'b1;
                wb_entry.re    = take ? r_s1_re : cur_re;
                wb_entry.im    = take ? r_s1_im : cur_im;
                wb_entry.mag   = take ? s_mag   : cur_mag;
            end
            default: begin
                wb_entry = '0;   // read-and-clear drops the bin
            end
        endcase
    end

    assign s1_wr = s1_go && s1_in_range
                && (r_s1_op == OP_ACCUM || r_s1_op == OP_READ_CLEAR);

    // ---------------------------------------------------------------- sweep FSM
    always_comb begin
        n_state      = r_state;
        n_sweep_addr = '0;
        case (r_state)
            ST_SWEEP: begin
                n_sweep_addr = r_sweep_addr + 1'b1;
                if (r_sweep_addr == BIN_AW'(NUM_BINS - 1)) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (s1_go && r_s1_op == OP_CLEAR_ALL) begin
                    n_state = ST_SWEEP;
                end
            end
            default: begin
                n_state = ST_SWEEP;
            end
        endcase
    end

    always_comb begin
        sweeping    = 1'b0;
        ram_wr_en   = s1_wr;
        ram_wr_addr = s1_addr;
        ram_wr_data = wb_entry;
        case (r_state)
            ST_SWEEP: begin
                sweeping    = 1'b1;
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_sweep_addr;
                ram_wr_data = '0;
            end
            ST_RUN: begin
                sweeping = 1'b0;
            end
            default: begin
                sweeping = 1'b1;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    assign cfg_sq = MAG_W'(i_cfg_wr_data) * MAG_W'(i_cfg_wr_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_empty_real <= {1'b1, {(CW-1){1'b0}}};
            r_empty_mag  <= MAG_W'(1) << (MAG_W - 2);
            r_s1_valid   <= 1'b0;
            r_fwd_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;

            if (i_cfg_wr_en) begin
                r_empty_real <= i_cfg_wr_data;
                r_empty_mag  <= {1'b0, cfg_sq[MAG_W-2:0]};
            end

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end

            if (sweeping) begin
                r_fwd_valid <= 1'b0;
            end else if (s1_wr) begin
                r_fwd_valid <= 1'b1;
            end

            if (s1_go && r_s1_op == OP_READ_CLEAR) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= i_opcode;
            r_s1_idx   <= i_bin_index;
            r_s1_re    <= i_sample_real;
            r_s1_im    <= i_sample_imag;
            r_s1_sq_re <= in_sq_re[MAG_W-2:0];
            r_s1_sq_im <= in_sq_im[MAG_W-2:0];
        end
        if (s1_wr) begin
            r_fwd_addr <= s1_addr;
            r_fwd_data <= wb_entry;
        end
        if (s1_go && r_s1_op == OP_READ_CLEAR) begin
            r_out_idx <= r_s1_idx;
            r_out_re  <= cur_re;
            r_out_im  <= cur_im;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_index = r_out_idx;
    assign o_max_real     = r_out_re;
    assign o_max_imag     = r_out_im;

endmodule

@@ hdl/gcmm_checker.sv @@
`include "grouped_complex_max_magnitude_macros.svh"

module gcmm_checker (
    input logic                                       i_clk,
    input logic                                       i_rst_n,
    input logic                                       i_cfg_wr_en,
    input logic signed [gcmm_pkg::COMPONENT_WIDTH-1:0] i_cfg_wr_data,
    input logic                                       i_valid,
    input logic                                       o_stall,
    input logic [gcmm_pkg::OP_W-1:0]                  i_opcode,
    input logic [gcmm_pkg::INDEX_W-1:0]               i_bin_index,
    input logic signed [gcmm_pkg::COMPONENT_WIDTH-1:0] i_sample_real,
    input logic signed [gcmm_pkg::COMPONENT_WIDTH-1:0] i_sample_imag,
    input logic                                       o_valid,
    input logic                                       i_stall,
    input logic [gcmm_pkg::INDEX_W-1:0]               o_result_index,
    input logic signed [gcmm_pkg::COMPONENT_WIDTH-1:0] o_max_real,
    input logic signed [gcmm_pkg::COMPONENT_WIDTH-1:0] o_max_imag
);

    import gcmm_pkg::*;

    // bins are being cleared right after reset
    `GCMM_ASSERT_AFTER_RESET(a_stall_after_reset, o_stall, "input not stalled after reset")

    // a clear-all request blocks the next request
    `GCMM_ASSERT_NEXT(a_clear_all_stalls, (i_valid && !o_stall && i_opcode == OP_CLEAR_ALL), o_stall, "clear-all did not stall input")

    // no result without a request taken earlier
    `GCMM_ASSERT_NEXT(a_no_spurious_result, (!(i_valid && !o_stall) ##1 !o_valid), !o_valid, "result without request")

    // stalled result holds
    `GCMM_ASSERT_NEXT(a_result_holds, (o_valid && i_stall), (o_valid && $stable(o_result_index) && $stable(o_max_real) && $stable(o_max_imag)), "stalled result changed")

endmodule

bind grouped_complex_max_magnitude gcmm_checker u_gcmm_checker (.*);

@@ test/grouped_complex_max_magnitude_tb.sv @@
module grouped_complex_max_magnitude_tb;
    import gcmm_pkg::*;

    localparam int CW           = COMPONENT_WIDTH;
    localparam int NUM_HOT      = 4;      // bins that a phase keeps hitting
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 106;
    localparam int NUM_DIR      = 28;
    localparam int DRAIN_CYCLES = 6;      // margin after the last read result
    localparam int LIMIT_CYCLES = 400000;

    // opcode 3 has no name in the package; the block must ignore it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [CW-1:0] CMP_MIN = 16'sh8000;
    localparam logic signed [CW-1:0] CMP_MAX = 16'sh7FFF;

    // one read result as the scoreboard holds it
    typedef struct packed {
        logic [INDEX_W-1:0]   idx;
        logic signed [CW-1:0] re;
        logic signed [CW-1:0] im;
    } t_bin_read;

    // directed row: either a register write (value in re) or a request;
    // when typed is set the expected read is taken from the row itself
    typedef struct packed {
        logic                 wr_cfg;
        logic [OP_W-1:0]      op;
        logic [INDEX_W-1:0]   idx;
        logic signed [CW-1:0] re;
        logic signed [CW-1:0] im;
        logic                 typed;
        logic signed [CW-1:0] want_re;
        logic signed [CW-1:0] want_im;
    } t_dir_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_wr_en;
    logic signed [CW-1:0]           i_cfg_wr_data;
    logic                           i_valid;
    logic                           o_stall;
    logic [OP_W-1:0]                i_opcode;
    logic [INDEX_W-1:0]             i_bin_index;
    logic signed [CW-1:0]           i_sample_real;
    logic signed [CW-1:0]           i_sample_imag;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic [INDEX_W-1:0]             o_result_index;
    logic signed [CW-1:0]           o_max_real;
    logic signed [CW-1:0]           o_max_imag;

    // shadow of the bin memory and the empty-bin register
    logic signed [CW-1:0] held_re [NUM_BINS];
    logic signed [CW-1:0] held_im [NUM_BINS];
    bit                   held_live [NUM_BINS];
    logic signed [CW-1:0] empty_re;

    t_bin_read pending_reads [$];
    int        mismatches  = 0;
    int        cycle_count = 0;
    int        stall_left  = 0;
    bit        steady_flow = 1'b1;  // no idling on either side while set

    // Directed part. Reset value of the register first (-32768, magnitude 2^30),
    // then 32767, then 0.
    t_dir_row dir_rows [NUM_DIR] = '{
        // reads of cleared bins at both ends of the index range
        '{1'b0, OP_READ_CLEAR, 10'd0,    16'sd0,      16'sd0,  1'b1, CMP_MIN, 16'sd0},
        '{1'b0, OP_READ_CLEAR, 10'd1023, 16'sd0,      16'sd0,  1'b1, CMP_MIN, 16'sd0},
        // small sample loses against the empty value
        '{1'b0, OP_ACCUM,      10'd5,    16'sd100,    16'sd200, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, OP_READ_CLEAR, 10'd5,    16'sd0,      16'sd0,  1'b1, CMP_MIN, 16'sd0},
        // largest magnitude wins, back to back into one bin
        '{1'b0, OP_ACCUM,      10'd6,    CMP_MIN,     CMP_MIN, 1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_ACCUM,      10'd6,    CMP_MAX,     CMP_MAX, 1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_READ_CLEAR, 10'd6,    16'sd0,      16'sd0,  1'b1, CMP_MIN, CMP_MIN},
        // second read sees the bin cleared
        '{1'b0, OP_READ_CLEAR, 10'd6,    16'sd0,      16'sd0,  1'b1, CMP_MIN, 16'sd0},
        // tie against the empty value keeps the empty value
        '{1'b0, OP_ACCUM,      10'd7,    16'sd0,      CMP_MIN, 1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_READ_CLEAR, 10'd7,    16'sd0,      16'sd0,  1'b1, CMP_MIN, 16'sd0},
        '{1'b0, OP_ACCUM,      10'd8,    CMP_MAX,     CMP_MAX, 1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_ACCUM,      10'd8,    -16'sd1,     CMP_MIN, 1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_READ_CLEAR, 10'd8,    16'sd0,      16'sd0,  1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_ACCUM,      10'd9,    -16'sd21846, 16'sd21845, 1'b0, 16'sd0, 16'sd0},
        // clear-all drops bin 9
        '{1'b0, OP_CLEAR_ALL,  10'd9,    16'sd0,      16'sd0,  1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_READ_CLEAR, 10'd9,    16'sd0,      16'sd0,  1'b1, CMP_MIN, 16'sd0},
        // unused opcode leaves bin 10 untouched
        '{1'b0, OP_UNUSED,     10'd10,   16'sd1,      16'sd1,  1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_READ_CLEAR, 10'd10,   16'sd0,      16'sd0,  1'b1, CMP_MIN, 16'sd0},
        // new register value shows in bins that were already cleared
        '{1'b1, OP_ACCUM,      10'd0,    CMP_MAX,     16'sd0,  1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_READ_CLEAR, 10'd3,    16'sd0,      16'sd0,  1'b1, CMP_MAX, 16'sd0},
        '{1'b0, OP_ACCUM,      10'd3,    16'sd0,      CMP_MAX, 1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_READ_CLEAR, 10'd3,    16'sd0,      16'sd0,  1'b1, CMP_MAX, 16'sd0},
        '{1'b0, OP_ACCUM,      10'd4,    -16'sd1,     16'sd0,  1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_ACCUM,      10'd4,    16'sd21845,  -16'sd21846, 1'b0, 16'sd0, 16'sd0},
        '{1'b0, OP_READ_CLEAR, 10'd4,    16'sd0,      16'sd0,  1'b0, 16'sd0,  16'sd0},
        // empty value zero: a zero sample ties and the bin holds (0, 0)
        '{1'b1, OP_ACCUM,      10'd0,    16'sd0,      16'sd0,  1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_ACCUM,      10'd11,   16'sd0,      16'sd0,  1'b0, 16'sd0,  16'sd0},
        '{1'b0, OP_READ_CLEAR, 10'd11,   16'sd0,      16'sd0,  1'b1, 16'sd0,  16'sd0}
    };

    grouped_complex_max_magnitude i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_bin_index    (i_bin_index),
        .i_sample_real  (i_sample_real),
        .i_sample_imag  (i_sample_imag),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_index (o_result_index),
        .o_max_real     (o_max_real),
        .o_max_imag     (o_max_imag)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // exact squared magnitude; 2 * 2^30 fits easily in 64 bits
    function automatic longint sq_mag(input logic signed [CW-1:0] re,
                                      input logic signed [CW-1:0] im);
        longint a;
        longint b;
        a = re;
        b = im;
        return a * a + b * b;
    endfunction

    // Applies one accepted request to the shadow bins. Returns 1 with the
    // expected read in rd for a read-and-clear request, else 0.
    // The index field is 10 bits wide, so it never reaches NUM_BINS.
    function automatic bit track_bin_max(input logic [OP_W-1:0] op,
                                         input logic [INDEX_W-1:0] idx,
                                         input logic signed [CW-1:0] re,
                                         input logic signed [CW-1:0] im,
                                         output t_bin_read rd);
        logic signed [CW-1:0] cur_re;
        logic signed [CW-1:0] cur_im;
        bit                   has_read;
        has_read = 1'b0;
        rd       = '0;
        // a cleared bin stands for (empty value, 0) with the value current now
        cur_re = held_live[idx] ? held_re[idx] : empty_re;
        cur_im = held_live[idx] ? held_im[idx] : '0;
        case (op)
            OP_ACCUM: begin
                // strictly greater replaces; a tie keeps what is held
                if (sq_mag(re, im) > sq_mag(cur_re, cur_im)) begin
                    cur_re = re;
                    cur_im = im;
                end
                held_re[idx]   = cur_re;
                held_im[idx]   = cur_im;
                held_live[idx] = 1'b1;
            end
            OP_READ_CLEAR: begin
                rd             = '{idx, cur_re, cur_im};
                held_live[idx] = 1'b0;
                has_read       = 1'b1;
            end
            OP_CLEAR_ALL: begin
                foreach (held_live[i]) held_live[i] = 1'b0;
            end
            default: ;
        endcase
        return has_read;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 92) return $urandom_range(3, 6);
        return $urandom_range(20, 40);
    endfunction

    // sample component biased toward the extremes and tiny values
    function automatic logic signed [CW-1:0] comp_value();
        case ($urandom_range(0, 9))
            0:       return CMP_MIN;
            1:       return CMP_MAX;
            2:       return '0;
            3:       return CW'($urandom_range(0, 8) - 4);
            default: return CW'($urandom);
        endcase
    endfunction

    // Drives one request from a falling edge, holds it until taken, and
    // returns on the falling edge after acceptance with valid still high.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                input logic signed [CW-1:0] re,
                                input logic signed [CW-1:0] im,
                                input bit typed, input logic signed [CW-1:0] want_re,
                                input logic signed [CW-1:0] want_im);
        int        gap;
        t_bin_read rd;
        gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : idle_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_opcode      <= op;
        i_bin_index   <= idx;
        i_sample_real <= re;
        i_sample_imag <= im;
        do @(posedge i_clk); while (o_stall);
        if (track_bin_max(op, idx, re, im, rd)) begin
            if (typed) begin
                rd.re = want_re;
                rd.im = want_im;
            end
            pending_reads.push_back(rd);
        end
        @(negedge i_clk);
    endtask

    // wait until every read has come back and the pipeline has emptied;
    // with valid low the input only stalls while a clear-all sweep runs
    task automatic drain_reads();
        i_valid <= 1'b0;
        while (pending_reads.size() != 0) @(negedge i_clk);
        while (o_stall) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_empty_value(input logic signed [CW-1:0] val);
        drain_reads();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        empty_re = val;
    endtask

    // receiver: random stall bursts, none started while steady_flow is set
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else begin
            i_stall <= 1'b0;
            if (!steady_flow && $urandom_range(0, 3) == 0) stall_left <= idle_gap();
        end
    end

    // result checker: every taken result against the oldest expected read
    always @(posedge i_clk) begin
        t_bin_read want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_reads.size() == 0) begin
                $error("unexpected read result: result_index %0d max_real %0d max_imag %0d",
                       o_result_index, o_max_real, o_max_imag);
                mismatches++;
            end else begin
                want = pending_reads.pop_front();
                if (o_result_index !== want.idx) begin
                    $error("result_index: expected %0d, actual %0d", want.idx, o_result_index);
                    mismatches++;
                end
                if (o_max_real !== want.re) begin
                    $error("max_real: expected %0d, actual %0d", want.re, o_max_real);
                    mismatches++;
                end
                if (o_max_imag !== want.im) begin
                    $error("max_imag: expected %0d, actual %0d", want.im, o_max_imag);
                    mismatches++;
                end
            end
        end
    end

    // watchdog; covers the post-reset sweep and every clear-all sweep
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [OP_W-1:0]      op;
        logic [INDEX_W-1:0]   idx;
        logic signed [CW-1:0] re;
        logic signed [CW-1:0] im;
        logic signed [CW-1:0] cur_re;
        logic signed [CW-1:0] cur_im;
        logic signed [CW-1:0] phase_val;
        logic [INDEX_W-1:0]   hot_bin [NUM_HOT];
        int                   pick;
        int                   slot;

        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        i_valid       = 1'b0;
        i_opcode      = OP_ACCUM;
        i_bin_index   = '0;
        i_sample_real = '0;
        i_sample_imag = '0;
        empty_re      = CMP_MIN;  // register reset value

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows, back to back so same-bin requests hit the bypass
        foreach (dir_rows[n]) begin
            if (dir_rows[n].wr_cfg)
                set_empty_value(dir_rows[n].re);
            else
                send_request(dir_rows[n].op, dir_rows[n].idx, dir_rows[n].re,
                             dir_rows[n].im, dir_rows[n].typed, dir_rows[n].want_re,
                             dir_rows[n].want_im);
        end

        // Random phases. Each one sets the empty value, then mostly accumulates
        // into a few hot bins and reads them back, with scattered requests,
        // unused opcodes and the odd clear-all mixed in.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       phase_val = CMP_MAX;
                1:       phase_val = '0;
                2:       phase_val = CMP_MIN;
                3:       phase_val = -16'sd1;
                default: phase_val = CW'($urandom);
            endcase
            set_empty_value(phase_val);
            steady_flow = (phase % 3 == 2);
            for (int k = 0; k < NUM_HOT; k++)
                hot_bin[k] = INDEX_W'($urandom_range(0, NUM_BINS - 1));
            // one hot bin at an end of the index range
            hot_bin[0] = phase[0] ? '1 : '0;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 199);
                slot = $urandom_range(0, NUM_HOT - 1);
                op   = OP_ACCUM;
                idx  = hot_bin[slot];
                re   = comp_value();
                im   = comp_value();
                if (pick < 3) begin
                    op = OP_CLEAR_ALL;
                end else if (pick < 7) begin
                    op  = OP_UNUSED;
                    idx = INDEX_W'($urandom_range(0, NUM_BINS - 1));
                end else if (pick < 21) begin
                    idx = INDEX_W'($urandom_range(0, NUM_BINS - 1));
                end else if (pick < 31) begin
                    op  = OP_READ_CLEAR;
                    idx = INDEX_W'($urandom_range(0, NUM_BINS - 1));
                end else if (pick < 140) begin
                    // sometimes probe the strict compare with an equal magnitude
                    cur_re = held_live[idx] ? held_re[idx] : empty_re;
                    cur_im = held_live[idx] ? held_im[idx] : '0;
                    case ($urandom_range(0, 5))
                        0: begin re = -cur_re; im = cur_im;  end
                        1: begin re = cur_im;  im = cur_re;  end
                        2: begin re = cur_re;  im = -cur_im; end
                        default: ;
                    endcase
                end else begin
                    op = OP_READ_CLEAR;
                end
                send_request(op, idx, re, im, 1'b0, '0, '0);
            end
        end

        drain_reads();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
